### sv/ulbc_pkg.sv
// ============================================================================
// ulbc_pkg
// Shared types, character codes and mask tables for the LED blink controller.
// ============================================================================
package ulbc_pkg;

   localparam int LED_NUM_DEFAULT   = 8;
   localparam int CMD_BYTES_DEFAULT = 32;
   localparam int PATTERN_LEN       = 16;
   localparam int PHASE_W           = $clog2(PATTERN_LEN);
   localparam int MASK_W            = PATTERN_LEN;
   localparam int LEVEL_W           = 8;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_UPZ   = 8'h5A;
   localparam logic [7:0] CH_LOWZ  = 8'h7A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ERR   = 8'h45;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_1     = 8'h31;
   localparam logic [7:0] CH_2     = 8'h32;
   localparam logic [7:0] CH_3     = 8'h33;
   localparam logic [7:0] CH_4     = 8'h34;
   localparam logic [7:0] CH_5     = 8'h35;

   localparam logic [MASK_W-1:0] MASK_OFF  = 16'h0000;
   localparam logic [MASK_W-1:0] MASK_ON   = 16'hFFFF;
   localparam logic [MASK_W-1:0] MASK_SLOW = 16'hFF00;
   localparam logic [MASK_W-1:0] MASK_MID  = 16'hF0F0;
   localparam logic [MASK_W-1:0] MASK_FAST = 16'hCCCC;
   localparam logic [MASK_W-1:0] MASK_MAX  = 16'hAAAA;

   typedef enum logic [1:0] {
      KIND_LEVELS   = 2'd0,
      KIND_REPLY    = 2'd1,
      KIND_OVERFLOW = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BYTE,
      ST_SCAN,
      ST_REP_Z,
      ST_REP_SP,
      ST_REP_LED,
      ST_TICK,
      ST_TICK_OUT
   } state_type;

   typedef struct packed {
      logic              hit;
      logic [MASK_W-1:0] mask;
   } mask_decode_type;

   // Command character to blink mask; hit is low for characters that change nothing.
   function automatic mask_decode_type decode_char(input logic [7:0] c);
      mask_decode_type d;
      d.hit  = 1'b1;
      d.mask = MASK_OFF;
      unique case (c)
         CH_0:    d.mask = MASK_OFF;
         CH_1:    d.mask = MASK_ON;
         CH_2:    d.mask = MASK_SLOW;
         CH_3:    d.mask = MASK_MID;
         CH_4:    d.mask = MASK_FAST;
         CH_5:    d.mask = MASK_MAX;
         default: d.hit = 1'b0;
      endcase
      return d;
   endfunction

   // Blink mask back to its state character.
   function automatic logic [7:0] encode_mask(input logic [MASK_W-1:0] m);
      logic [7:0] c;
      unique case (m)
         MASK_OFF:  c = CH_0;
         MASK_ON:   c = CH_1;
         MASK_SLOW: c = CH_2;
         MASK_MID:  c = CH_3;
         MASK_FAST: c = CH_4;
         MASK_MAX:  c = CH_5;
         default:   c = CH_ERR;
      endcase
      return c;
   endfunction

endpackage

### sv/ulbc_ram.sv
// ============================================================================
// ulbc_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module ulbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/ulbc_ctrl.sv
// ============================================================================
// ulbc_ctrl
// Sequencer: stores command bytes, scans commands, builds replies and ticks.
// ============================================================================
module ulbc_ctrl #(
   parameter int LED_NUM   = ulbc_pkg::LED_NUM_DEFAULT,
   parameter int CMD_BYTES = ulbc_pkg::CMD_BYTES_DEFAULT,
   parameter int CAW       = $clog2(CMD_BYTES),
   parameter int LED_AW    = (LED_NUM > 1) ? $clog2(LED_NUM) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic [7:0]                   req_rx_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_kind,
   output logic [ulbc_pkg::LEVEL_W-1:0] rsp_led_levels,
   output logic [7:0]                   rsp_tx_byte,
   output logic                         rsp_last,
   output logic                         buf_we,
   output logic [CAW-1:0]               buf_waddr,
   output logic [7:0]                   buf_wdata,
   output logic                         buf_re,
   output logic [CAW-1:0]               buf_raddr,
   input  logic [7:0]                   buf_rdata,
   output logic                         led_we,
   output logic [LED_AW-1:0]            led_waddr,
   output logic [ulbc_pkg::MASK_W-1:0]  led_wdata,
   output logic                         led_re,
   output logic [LED_AW-1:0]            led_raddr,
   input  logic [ulbc_pkg::MASK_W-1:0]  led_rdata
);
   import ulbc_pkg::*;

   localparam int FW    = $clog2(CMD_BYTES + 1);
   localparam int OFF_W = ((CAW > LED_AW) ? CAW : LED_AW) + 1;
   localparam int NL    = (LED_NUM < LEVEL_W) ? LED_NUM : LEVEL_W;

   state_type            state_ff, state_in;
   logic [7:0]           byte_ff, byte_in;
   logic [FW-1:0]        fill_ff, fill_in;
   logic [CAW-1:0]       pos_ff, pos_in;
   logic [LED_AW-1:0]    led_ff, led_in;
   logic [LEVEL_W-1:0]   lv_ff, lv_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [LED_NUM-1:0]   led_valid_ff, led_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             rsp_kind_ff, rsp_kind_in;
   logic [LEVEL_W-1:0]   rsp_lv_ff, rsp_lv_in;
   logic [7:0]           rsp_tx_ff, rsp_tx_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 slot_free;
   logic                 emit;
   kind_type             emit_kind;
   logic [LEVEL_W-1:0]   emit_lv;
   logic [7:0]           emit_tx;
   logic                 emit_last;
   logic [7:0]           scan_char;
   logic [OFF_W-1:0]     led_off;
   mask_decode_type      dec;
   logic [MASK_W-1:0]    cur_mask;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Bytes at or past the fill count read as zero; the buffer memory itself is never cleared.
   assign scan_char = ({1'b0, pos_ff} < (CAW + 1)'(fill_ff)) ? buf_rdata : CH_NUL;
   assign led_off   = OFF_W'(pos_ff) - OFF_W'(2);
   assign dec       = decode_char(scan_char);
   assign cur_mask  = led_valid_ff[led_ff] ? led_rdata : MASK_OFF;

   always_comb begin
      state_in     = state_ff;
      byte_in      = byte_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      led_in       = led_ff;
      lv_in        = lv_ff;
      phase_in     = phase_ff;
      led_valid_in = led_valid_ff;
      emit         = 1'b0;
      emit_kind    = KIND_LEVELS;
      emit_lv      = '0;
      emit_tx      = '0;
      emit_last    = 1'b0;
      buf_we       = 1'b0;
      buf_waddr    = '0;
      buf_wdata    = byte_ff;
      buf_re       = 1'b0;
      buf_raddr    = '0;
      led_we       = 1'b0;
      led_waddr    = led_off[LED_AW-1:0];
      led_wdata    = dec.mask;
      led_re       = 1'b0;
      led_raddr    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               byte_in = req_rx_byte;
               if (req_func) begin
                  led_re   = 1'b1;
                  led_in   = '0;
                  lv_in    = '0;
                  state_in = ST_TICK;
               end else begin
                  state_in = ST_BYTE;
               end
            end
         end

         ST_BYTE: begin
            if (fill_ff == FW'(CMD_BYTES)) begin
               // Full buffer: report, restart the buffer, keep the new byte unless it is a carriage return.
               if (slot_free) begin
                  emit      = 1'b1;
                  emit_kind = KIND_OVERFLOW;
                  emit_last = 1'b1;
                  if (byte_ff != CH_CR) begin
                     buf_we  = 1'b1;
                     fill_in = FW'(1);
                  end else begin
                     fill_in = '0;
                  end
                  state_in = ST_IDLE;
               end
            end else if (byte_ff == CH_CR) begin
               if (fill_ff < FW'(2)) begin
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  buf_re   = 1'b1;
                  pos_in   = '0;
                  state_in = ST_SCAN;
               end
            end else begin
               buf_we    = 1'b1;
               buf_waddr = fill_ff[CAW-1:0];
               fill_in   = fill_ff + FW'(1);
               state_in  = ST_IDLE;
            end
         end

         ST_SCAN: begin
            priority if ((pos_ff == CAW'(0) && scan_char != CH_UPZ) ||
                         (pos_ff == CAW'(1) && scan_char != CH_SPACE)) begin
               fill_in  = '0;
               state_in = ST_IDLE;
            end else if (pos_ff >= CAW'(2) && scan_char == CH_NUL) begin
               fill_in  = '0;
               state_in = ST_REP_Z;
            end else begin
               if (pos_ff >= CAW'(2) && dec.hit && 32'(led_off) < LED_NUM) begin
                  led_we                                = 1'b1;
                  led_valid_in[led_off[LED_AW-1:0]] = 1'b1;
               end
               if (pos_ff == CAW'(CMD_BYTES - 1)) begin
                  fill_in  = '0;
                  state_in = ST_REP_Z;
               end else begin
                  buf_re    = 1'b1;
                  buf_raddr = pos_ff + CAW'(1);
                  pos_in    = pos_ff + CAW'(1);
               end
            end
         end

         ST_REP_Z: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_kind = KIND_REPLY;
               emit_tx   = CH_LOWZ;
               state_in  = ST_REP_SP;
            end
         end

         ST_REP_SP: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_kind = KIND_REPLY;
               emit_tx   = CH_SPACE;
               led_re    = 1'b1;
               led_in    = '0;
               state_in  = ST_REP_LED;
            end
         end

         ST_REP_LED: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_kind = KIND_REPLY;
               emit_tx   = encode_mask(cur_mask);
               if (led_ff == LED_AW'(LED_NUM - 1)) begin
                  emit_last = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  led_re    = 1'b1;
                  led_raddr = led_ff + LED_AW'(1);
                  led_in    = led_ff + LED_AW'(1);
               end
            end
         end

         ST_TICK: begin
            lv_in = lv_ff | (LEVEL_W'(cur_mask[phase_ff]) << led_ff);
            if (led_ff == LED_AW'(NL - 1)) begin
               state_in = ST_TICK_OUT;
            end else begin
               led_re    = 1'b1;
               led_raddr = led_ff + LED_AW'(1);
               led_in    = led_ff + LED_AW'(1);
            end
         end

         ST_TICK_OUT: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_kind = KIND_LEVELS;
               emit_lv   = lv_ff;
               emit_last = 1'b1;
               phase_in  = phase_ff + PHASE_W'(1);
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_lv_in    = rsp_lv_ff;
      rsp_tx_in    = rsp_tx_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = emit_kind;
         rsp_lv_in    = emit_lv;
         rsp_tx_in    = emit_tx;
         rsp_last_in  = emit_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         phase_ff     <= '0;
         led_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         phase_ff     <= phase_in;
         led_valid_ff <= led_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      pos_ff      <= pos_in;
      led_ff      <= led_in;
      lv_ff       <= lv_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_lv_ff   <= rsp_lv_in;
      rsp_tx_ff   <= rsp_tx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_led_levels = rsp_lv_ff;
   assign rsp_tx_byte    = rsp_tx_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

### sv/uart_command_led_blink_controller_top.sv
// ============================================================================
// uart_command_led_blink_controller_top
// Gathers received UART bytes into commands, sets per-LED blink masks from
// "Z " commands with a reply of 2 + LED_NUM bytes, and emits LED levels on blink ticks.
// ============================================================================
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall req_func, req_rx_byte
//   rsp      out        rsp_valid/rsp_stall rsp_kind, rsp_led_levels,
//                                           rsp_tx_byte, rsp_last
//
// One transaction is handled at a time. A tick reads the LED mask memory once
// for each of the first min(LED_NUM, 8) LEDs. A carriage return walks the
// command buffer memory one byte a cycle (at most CMD_BYTES bytes) and, for
// a "Z " command, sends 2 + LED_NUM reply bytes, one per cycle unless rsp
// stalls. Reset is synchronous and clears the controller, fill count, phase,
// and mask valid bits; no clearing pass is needed. A stalled rsp only holds
// the sequencer when it has a further result to place in the output register.
// ============================================================================
module uart_command_led_blink_controller_top #(
   parameter int LED_NUM   = ulbc_pkg::LED_NUM_DEFAULT,
   parameter int CMD_BYTES = ulbc_pkg::CMD_BYTES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic [7:0]                   req_rx_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_kind,
   output logic [ulbc_pkg::LEVEL_W-1:0] rsp_led_levels,
   output logic [7:0]                   rsp_tx_byte,
   output logic                         rsp_last
);
   import ulbc_pkg::*;

   // Address widths of the two memories.
   localparam int CAW    = $clog2(CMD_BYTES);
   localparam int LED_AW = (LED_NUM > 1) ? $clog2(LED_NUM) : 1;

   // Command buffer memory port.
   logic              buf_we;
   logic [CAW-1:0]    buf_waddr;
   logic [7:0]        buf_wdata;
   logic              buf_re;
   logic [CAW-1:0]    buf_raddr;
   logic [7:0]        buf_rdata;

   // LED mask memory port. Entries never written read as off through the
   // valid bits held in the sequencer.
   logic              led_we;
   logic [LED_AW-1:0] led_waddr;
   logic [MASK_W-1:0] led_wdata;
   logic              led_re;
   logic [LED_AW-1:0] led_raddr;
   logic [MASK_W-1:0] led_rdata;

   ulbc_ram #(
      .WIDTH (8),
      .DEPTH (CMD_BYTES),
      .AW    (CAW)
   ) u_cmd_ram (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_waddr),
      .wr_data (buf_wdata),
      .rd_en   (buf_re),
      .rd_addr (buf_raddr),
      .rd_data (buf_rdata)
   );

   ulbc_ram #(
      .WIDTH (MASK_W),
      .DEPTH (LED_NUM),
      .AW    (LED_AW)
   ) u_mask_ram (
      .clock   (clock),
      .wr_en   (led_we),
      .wr_addr (led_waddr),
      .wr_data (led_wdata),
      .rd_en   (led_re),
      .rd_addr (led_raddr),
      .rd_data (led_rdata)
   );

   // The sequencer owns the fill count, blink phase and the output register.
   ulbc_ctrl #(
      .LED_NUM   (LED_NUM),
      .CMD_BYTES (CMD_BYTES),
      .CAW       (CAW),
      .LED_AW    (LED_AW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_led_levels (rsp_led_levels),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_last       (rsp_last),
      .buf_we         (buf_we),
      .buf_waddr      (buf_waddr),
      .buf_wdata      (buf_wdata),
      .buf_re         (buf_re),
      .buf_raddr      (buf_raddr),
      .buf_rdata      (buf_rdata),
      .led_we         (led_we),
      .led_waddr      (led_waddr),
      .led_wdata      (led_wdata),
      .led_re         (led_re),
      .led_raddr      (led_raddr),
      .led_rdata      (led_rdata)
   );

`ifndef SYNTHESIS
   // Only one transaction is in work at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another is in work");

   // LED levels and overflow reports are always the only or final result.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_LEVELS || rsp_kind == KIND_OVERFLOW) |-> rsp_last)
      else $error("level or overflow result without last");

   // Unused payload fields stay zero.
   a_clean_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_REPLY || rsp_tx_byte == 8'h00) &&
                    (rsp_kind == KIND_LEVELS || rsp_led_levels == '0))
      else $error("payload field set for the wrong kind");
`endif

endmodule

### sim/ulbc_blink_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// ulbc_blink_checker
// Watches the request and response channels of the LED blink controller,
// predicts the response transactions of every accepted request and compares
// them in order, field by field.
// ============================================================================
module ulbc_blink_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic                         req_func,
   input  logic [7:0]                   req_rx_byte,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [1:0]                   rsp_kind,
   input  logic [ulbc_pkg::LEVEL_W-1:0] rsp_led_levels,
   input  logic [7:0]                   rsp_tx_byte,
   input  logic                         rsp_last,
   output int                           error_count,
   output int                           results_pending
);
   import ulbc_pkg::*;

   localparam int LEDS = LED_NUM_DEFAULT;
   localparam int CMD  = CMD_BYTES_DEFAULT;

   typedef struct packed {
      kind_type           kind;
      logic [LEVEL_W-1:0] levels;
      logic [7:0]         tx;
      logic               last;
   } blink_result_type;

   blink_result_type   pending_results[$];
   logic [MASK_W-1:0]  mask_mem [LEDS];
   logic [7:0]         cmd_mem [CMD];
   int                 fill_level;
   logic [PHASE_W-1:0] phase;

   initial begin
      error_count     = 0;
      results_pending = 0;
   end

   function automatic logic [7:0] mask_state_char(input logic [MASK_W-1:0] m);
      logic [7:0] c;
      case (m)
         MASK_OFF:  c = CH_0;
         MASK_ON:   c = CH_1;
         MASK_SLOW: c = CH_2;
         MASK_MID:  c = CH_3;
         MASK_FAST: c = CH_4;
         MASK_MAX:  c = CH_5;
         default:   c = CH_ERR;
      endcase
      return c;
   endfunction

   task automatic clear_command();
      for (int i = 0; i < CMD; i++) cmd_mem[i] = CH_NUL;
      fill_level = 0;
   endtask

   task automatic queue_result(input kind_type k, input logic [LEVEL_W-1:0] lv,
                               input logic [7:0] tx);
      blink_result_type r;
      r.kind   = k;
      r.levels = lv;
      r.tx     = tx;
      r.last   = 1'b0;
      pending_results.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR at %0t ns: %s is %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic predict_blink_results(input logic is_tick, input logic [7:0] data);
      int                 start_size;
      int                 i;
      logic               hit;
      logic [MASK_W-1:0]  m;
      logic [LEVEL_W-1:0] lv;
      blink_result_type   tail;
      start_size = pending_results.size();
      if (is_tick) begin
         lv = '0;
         for (i = 0; i < LEDS && i < LEVEL_W; i++) lv[i] = mask_mem[i][phase];
         phase = phase + 1'b1;
         queue_result(KIND_LEVELS, lv, 8'h00);
      end else begin
         if (fill_level >= CMD) begin
            queue_result(KIND_OVERFLOW, '0, 8'h00);
            clear_command();
         end
         if (data == CH_CR) begin
            if (cmd_mem[0] == CH_UPZ && cmd_mem[1] == CH_SPACE) begin
               // A NUL ends the scan; unknown characters leave their LED alone.
               i = 2;
               while (i < CMD && cmd_mem[i] != CH_NUL) begin
                  hit = 1'b1;
                  m   = MASK_OFF;
                  case (cmd_mem[i])
                     CH_0:    m = MASK_OFF;
                     CH_1:    m = MASK_ON;
                     CH_2:    m = MASK_SLOW;
                     CH_3:    m = MASK_MID;
                     CH_4:    m = MASK_FAST;
                     CH_5:    m = MASK_MAX;
                     default: hit = 1'b0;
                  endcase
                  if (hit && i - 2 < LEDS) mask_mem[i-2] = m;
                  i++;
               end
               queue_result(KIND_REPLY, '0, CH_LOWZ);
               queue_result(KIND_REPLY, '0, CH_SPACE);
               for (i = 0; i < LEDS; i++) queue_result(KIND_REPLY, '0, mask_state_char(mask_mem[i]));
            end
            clear_command();
         end else if (fill_level < CMD) begin
            cmd_mem[fill_level] = data;
            fill_level++;
         end
      end
      if (pending_results.size() > start_size) begin
         tail      = pending_results.pop_back();
         tail.last = 1'b1;
         pending_results.push_back(tail);
      end
   endtask

   always @(posedge clock) begin
      blink_result_type want;
      if (reset) begin
         pending_results.delete();
         for (int i = 0; i < LEDS; i++) mask_mem[i] = MASK_OFF;
         clear_command();
         phase = '0;
      end else begin
         if (req_valid && !req_stall) predict_blink_results(req_func, req_rx_byte);
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch("response with none pending, kind", rsp_kind, 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_kind !== want.kind) report_mismatch("kind", rsp_kind, want.kind);
               if (rsp_led_levels !== want.levels)
                  report_mismatch("led_levels", rsp_led_levels, want.levels);
               if (rsp_tx_byte !== want.tx) report_mismatch("tx_byte", rsp_tx_byte, want.tx);
               if (rsp_last !== want.last) report_mismatch("last", rsp_last, want.last);
            end
         end
      end
      results_pending <= pending_results.size();
   end

endmodule

### sim/uart_command_led_blink_controller_top_test.sv
`timescale 1ns / 100ps
// ============================================================================
// uart_command_led_blink_controller_top_test
// Drives UART bytes and blink ticks into the LED blink controller with random
// idle gaps and response stalls; a checker beside the block predicts every
// response transaction and counts mismatches for the final verdict.
// ============================================================================
module uart_command_led_blink_controller_top_test;
   import ulbc_pkg::*;

   // The character that leaves an LED's mask untouched in a set command.
   localparam logic [7:0] CH_KEEP = "X";

   // Cycles to linger after the last response: a full buffer scan plus the
   // reply bytes, with some margin for the sequencer to settle.
   localparam int SETTLE_CYCLES = CMD_BYTES_DEFAULT + LED_NUM_DEFAULT + 20;

   // Number of random request transactions; the forced overflow sequences
   // are included in this count.
   localparam int RANDOM_ITEMS = 90;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_func;
   logic [7:0]         req_rx_byte;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_kind;
   logic [LEVEL_W-1:0] rsp_led_levels;
   logic [7:0]         rsp_tx_byte;
   logic               rsp_last;

   int error_count;
   int results_pending;
   int items_sent;
   bit quiet;

   uart_command_led_blink_controller_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_led_levels (rsp_led_levels),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_last       (rsp_last)
   );

   // The checker sees exactly what the block sees and owns all prediction.
   ulbc_blink_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_led_levels  (rsp_led_levels),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last        (rsp_last),
      .error_count     (error_count),
      .results_pending (results_pending)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Idle lengths shared by both sides: mostly back to back or short, with
   // the odd long pause so that gaps land on every phase of the sequencer.
   function automatic int idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // Any byte except a carriage return, so buffer contents can be built up
   // without ending the command by accident.
   function automatic logic [7:0] data_byte();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if (c == CH_CR) c = c ^ 8'h80;
      return c;
   endfunction

   // Offers one request transaction and holds it until the block takes it.
   // Valid stays high into the next transaction when no gap follows, so it
   // is never lowered and raised within the same time step.
   task automatic send_item(input logic is_tick, input logic [7:0] data);
      int gap;
      req_valid   <= 1'b1;
      req_func    <= is_tick;
      req_rx_byte <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      gap = quiet ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
   endtask

   // Holds the sender back until every predicted response has been seen.
   // The pending count is updated by the checker at the edge itself, so the
   // value read here always reflects the previous edge.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
   endtask

   // A set command, mostly well formed. The LED characters are chosen from
   // the valid codes, the keep character, stray bytes, spaces and the odd
   // NUL; now and then the prefix is wrong so that the command is ignored,
   // and a few commands run past the eighth LED.
   task automatic send_led_command();
      int unsigned prefix;
      int unsigned len;
      int unsigned p;
      logic [7:0]  c;
      prefix = $urandom_range(0, 9);
      if (prefix == 0) begin
         send_item(1'b0, CH_UPZ);
         send_item(1'b0, data_byte());
      end else if (prefix == 1) begin
         send_item(1'b0, CH_LOWZ);
         send_item(1'b0, CH_SPACE);
      end else begin
         send_item(1'b0, CH_UPZ);
         send_item(1'b0, CH_SPACE);
      end
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 9) : $urandom_range(10, 29);
      repeat (len) begin
         p = $urandom_range(0, 19);
         if (p < 12)      c = CH_0 + 8'($urandom_range(0, 5));
         else if (p < 15) c = CH_KEEP;
         else if (p < 18) c = data_byte();
         else if (p < 19) c = CH_NUL;
         else             c = CH_SPACE;
         send_item(1'b0, c);
      end
      send_item(1'b0, CH_CR);
   endtask

   // Fills the command buffer to the brim from empty. A leading carriage
   // return flushes whatever earlier noise left behind.
   task automatic fill_command_buffer();
      send_item(1'b0, CH_CR);
      repeat (CMD_BYTES_DEFAULT) send_item(1'b0, data_byte());
   endtask

   // Response side: stretches with no stall at all alternate with stretches
   // of short and occasionally long stalls.
   initial begin
      int unsigned n;
      forever begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 6)) @(posedge clock);
            n = idle_len();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      int unsigned pick;
      int          target;
      bit          overflow_done;
      req_valid     <= 1'b0;
      req_func      <= 1'b0;
      req_rx_byte   <= 8'h00;
      reset         <= 1'b1;
      items_sent    = 0;
      quiet         = 1'b0;
      overflow_done = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A tick right after reset must show every LED dark,
      // and the byte that rides along with a tick is ignored.
      send_item(1'b1, 8'hFF);
      // Every mask code once, with the keep character on LED 6.
      send_text("Z 123450");
      send_item(1'b0, CH_KEEP);
      send_item(1'b0, CH_CR);
      send_item(1'b1, 8'h00);
      send_item(1'b1, 8'hA5);
      // A command without the set prefix produces nothing.
      send_text("Q");
      send_item(1'b0, CH_CR);
      // A NUL stops the scan, so the trailing '1' must not reach LED 2.
      send_text("Z 4");
      send_item(1'b0, CH_NUL);
      send_text("1");
      send_item(1'b0, CH_CR);
      // An empty command and a byte at the top of the range.
      send_item(1'b0, CH_CR);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, CH_CR);
      // Let everything come out before the random part starts.
      wait_for_drain();

      // Random part. Roughly half the sequences are set commands; the rest
      // are runs of ticks and noise bytes that may or may not end in a
      // carriage return. Somewhere in the middle the buffer is overrun both
      // by an ordinary byte that then starts a valid command and by a
      // carriage return that meets a full buffer.
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         quiet = ($urandom_range(0, 3) == 0);
         pick  = $urandom_range(0, 9);
         if (pick < 5) begin
            send_led_command();
         end else if (pick < 8) begin
            repeat ($urandom_range(1, 4)) send_item(1'b1, 8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 5)) send_item(1'b0, data_byte());
            if ($urandom_range(0, 1) == 1) send_item(1'b0, CH_CR);
         end
         if (!overflow_done && items_sent + 80 >= target) begin
            overflow_done = 1'b1;
            quiet = 1'b0;
            fill_command_buffer();
            send_item(1'b0, CH_UPZ);
            send_text(" 3");
            send_item(1'b0, CH_CR);
            fill_command_buffer();
            send_item(1'b0, CH_CR);
            wait_for_drain();
         end
      end

      // Wind down: wait for the last response, then give the block time to
      // show anything it should not send.
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("uart_command_led_blink_controller_top_test passed");
      end else begin
         $display("uart_command_led_blink_controller_top_test failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run even with every response
   // stalled to the limit.
   initial begin
      #20_000_000;
      $display("uart_command_led_blink_controller_top_test failed");
      $finish;
   end

endmodule

### sim.f
sv/ulbc_pkg.sv
sv/ulbc_ram.sv
sv/ulbc_ctrl.sv
sv/uart_command_led_blink_controller_top.sv
sim/ulbc_blink_checker.sv
sim/uart_command_led_blink_controller_top_test.sv
